@@ rtl/core/deq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// deq_pkg
// Shared constants for the double-ended queue: field widths, request modes,
// status codes and the configuration register map.
// ============================================================================
package deq_pkg;

    localparam int DATA_W        = 32;
    localparam int DEPTH_DEFAULT = 16;
    localparam int MODE_W        = 3;
    localparam int STATUS_W      = 2;
    localparam int SIZE_W        = 5;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PEEK_REAR  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // Register index is taken from the word address bit of paddr.
    localparam logic REG_SIZE_IN_USE = 1'b0;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

endpackage : deq_pkg
`default_nettype wire

@@ rtl/core/deq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module deq_ram #(
    parameter int WIDTH = deq_pkg::DATA_W,
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : deq_ram
`default_nettype wire

@@ rtl/core/double_ended_queue_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// double_ended_queue_core
// Circular-array double-ended queue of signed 32-bit words with push, pop
// and peek at either end, and a configurable active size.
// ============================================================================
//
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   mode, item_value
//  rsp      out        rsp_valid/rsp_stall   status, read_value, now_empty,
//                                            now_full
//  apb      in         psel/penable/pready   paddr, pwdata, prdata
//
// One request is taken per cycle unless req_stall is raised; its result appears
// in the cycle after, with a peeked word from the registered read of the slot
// RAM. The single result register holds a word under rsp_stall, and req_stall
// is raised while it does. Reset empties the queue and sets the size to 16; slot
// contents are not cleared. Any write to the size register also empties the queue.
//
module double_ended_queue_core #(
    parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Request channel
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire logic        [deq_pkg::MODE_W-1:0]  mode,
    input  wire logic signed [deq_pkg::DATA_W-1:0]  item_value,
    // Result channel
    output logic                                    rsp_valid,
    input  wire logic                               rsp_stall,
    output logic             [deq_pkg::STATUS_W-1:0] status,
    output logic signed      [deq_pkg::DATA_W-1:0]  read_value,
    output logic                                    now_empty,
    output logic                                    now_full,
    // Configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [deq_pkg::PADDR_W-1:0] paddr,
    input  wire logic        [deq_pkg::PDATA_W-1:0] pwdata,
    output logic             [deq_pkg::PDATA_W-1:0] prdata,
    output logic                                    pready
);

    import deq_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int SZ_W = IW + 1;

    logic [SIZE_W-1:0]   size_reg;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic                empty_reg, empty_next;

    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                peek_reg, peek_next;
    logic                now_empty_reg;
    logic                now_full_reg, now_full_next;

    logic [SZ_W-1:0]     sz;
    logic [IW-1:0]       sz_m1;
    logic                full_now;
    logic                accept;
    logic                cfg_write;

    logic                ram_wr_en;
    logic [IW-1:0]       ram_wr_addr;
    logic                ram_rd_en;
    logic [IW-1:0]       ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    function automatic logic [SZ_W-1:0] occupancy(
        input logic [IW-1:0]   head,
        input logic [IW-1:0]   tail,
        input logic            empty,
        input logic [SZ_W-1:0] size
    );
        logic [SZ_W-1:0] h;
        logic [SZ_W-1:0] t;
        h = SZ_W'(head);
        t = SZ_W'(tail);
        if (empty)
        begin
            return '0;
        end
        else if (tail >= head)
        begin
            return t - h + SZ_W'(1);
        end
        else
        begin
            // Wrapped case; the true count fits even if the sum overflows.
            return t + size - h + SZ_W'(1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_SIZE_IN_USE);
    assign prdata    = (paddr[2] == REG_SIZE_IN_USE) ? PDATA_W'(size_reg) : '0;

    // Effective size: zero acts as one, anything above the depth as the depth.
    always_comb
    begin
        if (size_reg == '0)
        begin
            sz = SZ_W'(1);
        end
        else if (int'(size_reg) > DEPTH)
        begin
            sz = SZ_W'(DEPTH);
        end
        else
        begin
            sz = SZ_W'(size_reg);
        end
    end

    assign sz_m1    = IW'(sz - SZ_W'(1));
    assign full_now = (occupancy(head_reg, tail_reg, empty_reg, sz) == sz);

    // ------------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------------
    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = STATUS_DONE;
        peek_next   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = head_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;

        case (mode)
            MODE_PUSH_FRONT:
            begin
                if (full_now)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    if (empty_reg)
                    begin
                        head_next  = sz_m1;
                        tail_next  = sz_m1;
                        empty_next = 1'b0;
                    end
                    else
                    begin
                        head_next = (head_reg == '0) ? sz_m1 : head_reg - IW'(1);
                    end
                    ram_wr_en   = accept;
                    ram_wr_addr = head_next;
                end
            end
            MODE_PUSH_REAR:
            begin
                if (full_now)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                    end
                    else
                    begin
                        tail_next = (tail_reg >= sz_m1) ? '0 : tail_reg + IW'(1);
                    end
                    ram_wr_en   = accept;
                    ram_wr_addr = tail_next;
                end
            end
            MODE_POP_FRONT:
            begin
                if (empty_reg)
                begin
                    status_next = STATUS_EMPTY;
                end
                else if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    head_next = (head_reg >= sz_m1) ? '0 : head_reg + IW'(1);
                end
            end
            MODE_POP_REAR:
            begin
                if (empty_reg)
                begin
                    status_next = STATUS_EMPTY;
                end
                else if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                end
                else
                begin
                    tail_next = (tail_reg == '0) ? sz_m1 : tail_reg - IW'(1);
                end
            end
            MODE_PEEK_FRONT:
            begin
                if (empty_reg)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    peek_next   = 1'b1;
                    ram_rd_en   = accept;
                    ram_rd_addr = head_reg;
                end
            end
            MODE_PEEK_REAR:
            begin
                if (empty_reg)
                begin
                    status_next = STATUS_EMPTY;
                end
                else
                begin
                    peek_next   = 1'b1;
                    ram_rd_en   = accept;
                    ram_rd_addr = tail_reg;
                end
            end
            default:
            begin
                // Unused modes leave the queue as it is.
            end
        endcase
    end

    assign now_full_next = (occupancy(head_next, tail_next, empty_next, sz) == sz);

    // ------------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SIZE_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                size_reg  <= pwdata[SIZE_W-1:0];
                head_reg  <= '0;
                tail_reg  <= '0;
                empty_reg <= 1'b1;
            end
            else if (accept)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end

            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_next;
            peek_reg      <= peek_next;
            now_empty_reg <= empty_next;
            now_full_reg  <= now_full_next;
        end
    end

    deq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (DATA_W'($unsigned(item_value))),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign read_value = peek_reg ? $signed(ram_rd_data) : '0;
    assign now_empty  = now_empty_reg;
    assign now_full   = now_full_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid
    ) else $error("accepted request produced no result");

    a_empty_indices_home: assert property (
        @(posedge clk) disable iff (!rst_n)
        empty_reg |-> (head_reg == '0) && (tail_reg == '0)
    ) else $error("empty queue with indices away from zero");

    a_indices_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty_reg |-> (SZ_W'(head_reg) < sz) && (SZ_W'(tail_reg) < sz)
    ) else $error("queue index beyond active size");

    a_reject_full_flag: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == STATUS_FULL)) |-> now_full && !now_empty
    ) else $error("full rejection without full flag");

endmodule : double_ended_queue_core
`default_nettype wire

@@ tb/tb_double_ended_queue_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_double_ended_queue_core
// Self-checking bench for the double-ended queue. A shadow deque predicts
// status, peeked word and fill flags for every request word. The sender runs
// in random bursts and the receiver stalls on its own pattern. The active
// size is rewritten between phases, including its out-of-range values.
// ============================================================================
module tb_double_ended_queue_core;

    import deq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic                     now_empty;
        logic                     now_full;
    } deq_result_t;

    class deq_scoreboard;
        logic [DATA_W-1:0] slot_mem [DEPTH_DEFAULT];
        logic [SIZE_W-1:0] size_reg;
        int                front_idx;
        int                rear_idx;
        bit                is_drained;
        deq_result_t       pending_results [$];
        int                failures;

        function new();
            size_reg   = SIZE_RESET;
            front_idx  = 0;
            rear_idx   = 0;
            is_drained = 1'b1;
            failures   = 0;
        endfunction

        function int active_size();
            if (size_reg == 0)
                return 1;
            if (size_reg > DEPTH_DEFAULT)
                return DEPTH_DEFAULT;
            return int'(size_reg);
        endfunction

        function int fill_level(int sz);
            if (is_drained)
                return 0;
            if (rear_idx >= front_idx)
                return rear_idx - front_idx + 1;
            return rear_idx + sz - front_idx + 1;
        endfunction

        // A size write also empties the queue.
        function void set_size(logic [SIZE_W-1:0] value);
            size_reg   = value;
            front_idx  = 0;
            rear_idx   = 0;
            is_drained = 1'b1;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_request(logic [MODE_W-1:0] op,
                                   logic signed [DATA_W-1:0] word);
            int          sz;
            bit          was_full;
            deq_result_t r;
            sz       = active_size();
            was_full = (fill_level(sz) == sz);
            r        = '0;
            r.status = STATUS_DONE;
            case (op)
                MODE_PUSH_FRONT:
                begin
                    if (was_full)
                        r.status = STATUS_FULL;
                    else
                    begin
                        if (is_drained)
                        begin
                            front_idx  = sz - 1;
                            rear_idx   = front_idx;
                            is_drained = 1'b0;
                        end
                        else
                            front_idx = (front_idx == 0) ? sz - 1 : front_idx - 1;
                        slot_mem[front_idx] = word;
                    end
                end
                MODE_PUSH_REAR:
                begin
                    if (was_full)
                        r.status = STATUS_FULL;
                    else
                    begin
                        if (is_drained)
                        begin
                            front_idx  = 0;
                            rear_idx   = 0;
                            is_drained = 1'b0;
                        end
                        else
                            rear_idx = (rear_idx >= sz - 1) ? 0 : rear_idx + 1;
                        slot_mem[rear_idx] = word;
                    end
                end
                MODE_POP_FRONT, MODE_POP_REAR:
                begin
                    if (is_drained)
                        r.status = STATUS_EMPTY;
                    else if (front_idx == rear_idx)
                        set_size(size_reg);
                    else if (op == MODE_POP_FRONT)
                        front_idx = (front_idx >= sz - 1) ? 0 : front_idx + 1;
                    else
                        rear_idx = (rear_idx == 0) ? sz - 1 : rear_idx - 1;
                end
                MODE_PEEK_FRONT, MODE_PEEK_REAR:
                begin
                    if (is_drained)
                        r.status = STATUS_EMPTY;
                    else
                        r.read_value =
                            slot_mem[(op == MODE_PEEK_FRONT) ? front_idx : rear_idx];
                end
                default:
                    ;
            endcase
            r.now_empty = is_drained;
            r.now_full  = (fill_level(sz) == sz);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status,
                                   logic signed [DATA_W-1:0] rd,
                                   logic empty_flag, logic full_flag);
            deq_result_t exp_r;
            if (pending_results.size() == 0)
            begin
                $error("result word arrived with no request outstanding");
                failures++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (status !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, status);
                failures++;
            end
            if (rd !== exp_r.read_value)
            begin
                $error("read_value: expected %0d, got %0d", exp_r.read_value, rd);
                failures++;
            end
            if (empty_flag !== exp_r.now_empty)
            begin
                $error("now_empty: expected %0d, got %0d", exp_r.now_empty, empty_flag);
                failures++;
            end
            if (full_flag !== exp_r.now_full)
            begin
                $error("now_full: expected %0d, got %0d", exp_r.now_full, full_flag);
                failures++;
            end
        endfunction
    endclass

    localparam int CLK_PERIOD    = 8;
    localparam int IDLE_LIMIT    = 1000;
    localparam int HOLD_CYCLES   = 60;
    localparam int PHASE_ITEMS   = 170;
    localparam int NUM_PHASES    = 10;
    localparam logic [MODE_W-1:0]  MODE_SPARE_A = 3'd6;
    localparam logic [MODE_W-1:0]  MODE_SPARE_B = 3'd7;
    localparam logic [PADDR_W-1:0] SIZE_ADDR    = {REG_SIZE_IN_USE, 2'b00};

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      req_valid  = 1'b0;
    logic                      req_stall;
    logic [MODE_W-1:0]         mode       = '0;
    logic signed [DATA_W-1:0]  item_value = '0;
    logic                      rsp_valid;
    logic                      rsp_stall  = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  read_value;
    logic                      now_empty;
    logic                      now_full;
    logic                      psel       = 1'b0;
    logic                      penable    = 1'b0;
    logic                      pwrite     = 1'b0;
    logic [PADDR_W-1:0]        paddr      = '0;
    logic [PDATA_W-1:0]        pwdata     = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;

    deq_scoreboard sb;
    int            burst_left = 0;
    int            hold_ask   = 0;

    double_ended_queue_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .mode       (mode),
        .item_value (item_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .read_value (read_value),
        .now_empty  (now_empty),
        .now_full   (now_full),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offers one request word and waits for it to be taken; a burst ends with
    // a random gap, which may be zero.
    task automatic send_request(input logic [MODE_W-1:0] op,
                                input logic signed [DATA_W-1:0] word);
        int gap;
        req_valid  <= 1'b1;
        mode       <= op;
        item_value <= word;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(op, word);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // The size may only change while nothing is in flight.
    task automatic drain_and_configure(input logic [SIZE_W-1:0] value);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SIZE_ADDR;
        pwdata  <= {{(PDATA_W - SIZE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_size(value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return $urandom_range(1) ? MODE_SPARE_B : MODE_SPARE_A;
        if (r < 3 + push_pct)
            return $urandom_range(1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
        if (r < 83)
            return $urandom_range(1) ? MODE_POP_REAR : MODE_POP_FRONT;
        return $urandom_range(1) ? MODE_PEEK_REAR : MODE_PEEK_FRONT;
    endfunction

    task automatic run_directed();
        send_request(MODE_PEEK_FRONT, 32'sd1);
        send_request(MODE_POP_REAR, 32'sd2);
        send_request(MODE_PEEK_REAR, 32'sd3);
        send_request(MODE_POP_FRONT, 32'sd4);
        send_request(MODE_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_request(MODE_PUSH_REAR, 32'sh8000_0000);
        send_request(MODE_PUSH_FRONT, -32'sd1);
        send_request(MODE_PUSH_REAR, 32'sd0);
        send_request(MODE_PEEK_FRONT, 32'sd0);
        send_request(MODE_PEEK_REAR, -32'sd1);
        send_request(MODE_SPARE_A, 32'sh5555_AAAA);
        send_request(MODE_SPARE_B, 32'shAAAA_5555);
        send_request(MODE_POP_FRONT, 32'sd0);
        send_request(MODE_POP_REAR, 32'sd0);
        send_request(MODE_POP_FRONT, 32'sd0);
        // Last item leaves from the rear and both ends go back to slot zero.
        send_request(MODE_POP_REAR, 32'sd0);
        drain_and_configure(5'd1);
        send_request(MODE_PUSH_REAR, 32'sh1234_5678);
        send_request(MODE_PUSH_FRONT, 32'sd9);
        send_request(MODE_PEEK_FRONT, 32'sd0);
        send_request(MODE_POP_REAR, 32'sd0);
        send_request(MODE_PEEK_REAR, 32'sd0);
    endtask

    // Receiver: checks every accepted result word and stalls on a pattern of
    // its own, with a long hold-off whenever the sender asks for one.
    int stall_span   = 0;
    int stall_pct    = 0;
    int hold_left    = 0;
    int holds_served = 0;

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(status, read_value, now_empty, now_full);
        if (stall_span == 0)
        begin
            stall_span = $urandom_range(64, 16);
            case ($urandom_range(4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 15;
                3:       stall_pct = 40;
                default: stall_pct = 75;
            endcase
        end
        else
            stall_span--;
        if (hold_ask != holds_served)
        begin
            holds_served = hold_ask;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
            rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [SIZE_W-1:0] phase_sizes [NUM_PHASES];
        int                sz;
        int                push_pct;
        int                seg_left;
        sb = new();
        phase_sizes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd15,
                        5'd16, 5'd0};
        phase_sizes[8] = SIZE_W'($urandom_range(16, 1));
        phase_sizes[9] = SIZE_W'($urandom_range(31, 0));
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_and_configure(phase_sizes[p]);
            sz = sb.active_size();
            seg_left = 0;
            push_pct = 60;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // Alternate push-heavy and pop-heavy stretches so the queue
                // keeps swinging between empty and full and wraps round.
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(3 * sz + 4, sz + 2);
                    push_pct = (push_pct > 40) ? 20 : 60;
                end
                else
                    seg_left--;
                if ((p == 1 || p == 5) && i == 40)
                    hold_ask <= hold_ask + 1;
                send_request(pick_mode(push_pct), pick_word());
            end
        end
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/double_ended_queue_core.sv
tb/tb_double_ended_queue_core.sv
